/* src/spq_pkg.sv */
`default_nettype none
package spq_pkg;
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;
   localparam int unsigned OCCUPANCY_WIDTH = 5;

   // control from the sequencer to the entry store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;
endpackage
`default_nettype wire

/* src/stable_priority_queue_top.sv */
`default_nettype none
// channel  | ports                                           | direction
// request  | req_valid req_ready req_kind req_item_data req_item_priority | in
// response | rsp_valid rsp_ready rsp_status rsp_out_data rsp_out_priority rsp_occupancy | out
// Entries live in one single-port-per-side RAM with a registered read.
// Accept to result valid: a full enqueue or an empty dequeue goes straight to the result;
// an enqueue reads entries from the tail down, shifting each one of higher priority value
// up until it places the new entry; a dequeue reads the head, then moves each entry down.
// One item at a time; input ready rises right after the result is accepted.
// Reset clears count and control only.
module stable_priority_queue_top #(
   parameter int unsigned CAPACITY       = 16,
   parameter int unsigned DATA_WIDTH     = 32,
   parameter int unsigned PRIORITY_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic signed [DATA_WIDTH-1:0]     req_item_data,
   input  wire logic signed [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic signed [DATA_WIDTH-1:0]          rsp_out_data,
   output logic signed [PRIORITY_WIDTH-1:0]      rsp_out_priority,
   output logic [spq_pkg::OCCUPANCY_WIDTH-1:0]   rsp_occupancy
);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned EW = DATA_WIDTH + PRIORITY_WIDTH;
   localparam int unsigned OW = spq_pkg::OCCUPANCY_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE, S_ENQ_RD, S_ENQ_CMP, S_DEQ_HEAD, S_DEQ_RD, S_DEQ_WR, S_DONE
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;   // enqueue: entry being examined + 1; dequeue: next source
   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [PRIORITY_WIDTH-1:0] prio_ff;
   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic signed [DATA_WIDTH-1:0] od_ff;
   logic signed [PRIORITY_WIDTH-1:0] op_ff;

   spq_pkg::mem_ctl_type ctl;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic signed [PRIORITY_WIDTH-1:0] rd_prio;

   spq_store #(.DEPTH(CAPACITY), .WIDTH(EW), .AW(AW)) u_store (
      .clock, .ctl, .rd_addr, .wr_addr, .wr_data, .rd_data
   );

   assign rd_prio   = rd_data[PRIORITY_WIDTH-1:0];
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      ctl = '0;
      rd_addr = '0;
      wr_addr = '0;
      wr_data = rd_data;
      unique case (state_ff)
         S_ENQ_RD: begin
            ctl.rd_en = 1'b1;
            rd_addr = AW'(idx_ff - CW'(1));
         end
         S_ENQ_CMP: begin
            ctl.wr_en = 1'b1;
            wr_addr = AW'(idx_ff);
            // shift this entry up, or place the new entry behind it
            if (!(idx_ff != '0 && rd_prio > prio_ff)) begin
               wr_data = {data_ff, prio_ff};
            end
         end
         S_DEQ_HEAD: begin
            ctl.rd_en = 1'b1;
            rd_addr = '0;
         end
         S_DEQ_RD: begin
            ctl.rd_en = 1'b1;
            rd_addr = AW'(idx_ff);
         end
         S_DEQ_WR: begin
            ctl.wr_en = 1'b1;
            wr_addr = AW'(idx_ff - CW'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  data_ff <= req_item_data;
                  prio_ff <= req_item_priority;
                  od_ff <= '0;
                  op_ff <= '0;
                  status_ff <= spq_pkg::STATUS_OK;
                  if (req_kind == spq_pkg::KIND_ENQUEUE) begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_ff <= spq_pkg::STATUS_FULL;
                        state_ff <= S_DONE;
                     end else if (count_ff == '0) begin
                        // empty store: place at slot 0 via the compare path
                        idx_ff <= '0;
                        state_ff <= S_ENQ_CMP;
                     end else begin
                        idx_ff <= count_ff;
                        state_ff <= S_ENQ_RD;
                     end
                  end else if (count_ff == '0) begin
                     status_ff <= spq_pkg::STATUS_EMPTY;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_DEQ_HEAD;
                  end
               end
            end
            S_ENQ_RD: state_ff <= S_ENQ_CMP;
            S_ENQ_CMP: begin
               if (idx_ff != '0 && rd_prio > prio_ff) begin
                  idx_ff <= idx_ff - CW'(1);
                  state_ff <= (idx_ff == CW'(1)) ? S_ENQ_CMP : S_ENQ_RD;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_DEQ_HEAD: begin
               idx_ff <= CW'(1);
               state_ff <= S_DEQ_RD;
            end
            S_DEQ_RD: begin
               if (idx_ff == CW'(1)) begin
                  od_ff <= rd_data[EW-1:PRIORITY_WIDTH];
                  op_ff <= rd_prio;
               end
               if (idx_ff >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DEQ_WR;
               end
            end
            S_DEQ_WR: begin
               idx_ff <= idx_ff + CW'(1);
               state_ff <= S_DEQ_RD;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_out_data = od_ff;
   assign rsp_out_priority = op_ff;
   assign rsp_occupancy = OW'(count_ff);

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count above capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en)) else $error("read and write together");
   a_ok_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != spq_pkg::STATUS_OK) |->
      (rsp_out_data == '0 && rsp_out_priority == '0)) else $error("payload on fail");
`endif
endmodule
`default_nettype wire

/* src/spq_store.sv */
`default_nettype none
module spq_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 48,
   parameter int unsigned AW    = 4
) (
   input  wire logic              clock,
   input  wire spq_pkg::mem_ctl_type ctl,
   input  wire logic [AW-1:0]     rd_addr,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[wr_addr] <= wr_data;
      if (ctl.rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
